>>> rtl/trje_pkg.sv
// shared types and constants of the token rate and jitter estimator
// used by trje_ctrl, trje_datapath and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package trje_pkg;

  localparam int Window = 16;
  localparam int SlotW = $clog2(Window);
  localparam int FillW = $clog2(Window + 1);

  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [2:0] REG_TARGET_RATE = 3'd1;
  localparam logic [2:0] REG_SCALE_FLOOR = 3'd2;
  localparam logic [2:0] REG_SCALE_CEILING = 3'd3;
  localparam logic [2:0] REG_CHANGE_THRESHOLD = 3'd4;

  localparam logic [1:0] STATUS_SEEDED = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_GAP = 2'd2;

  localparam logic [4:0] WINDOW_RESET = 5'd16;
  localparam logic [47:0] TARGET_RESET = 48'd3276800;
  localparam logic [23:0] SCALE_FLOOR_RESET = 24'd6554;
  localparam logic [23:0] SCALE_CEILING_RESET = 24'd655360;
  localparam logic [15:0] THRESHOLD_RESET = 16'd6554;
  localparam logic [23:0] ONE_Q16 = 24'd65536;
  // 1e9 ns per second in Q.16
  localparam logic [45:0] RATE_K = 46'd65536000000000;

  localparam logic [5:0] SQRT_LAST = 6'd52;
  localparam logic [5:0] DIV_LAST = 6'd63;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_ACCEPT = 4'd1;
  localparam logic [3:0] OP_WALK = 4'd2;
  localparam logic [3:0] OP_DRAIN = 4'd3;
  localparam logic [3:0] OP_SQ1 = 4'd4;
  localparam logic [3:0] OP_SQ2 = 4'd5;
  localparam logic [3:0] OP_SQRT = 4'd6;
  localparam logic [3:0] OP_CVLD = 4'd7;
  localparam logic [3:0] OP_DIV = 4'd8;
  localparam logic [3:0] OP_RTLD = 4'd9;
  localparam logic [3:0] OP_SCLD = 4'd10;
  localparam logic [3:0] OP_CLAMP = 4'd11;
  localparam logic [3:0] OP_FLAG1 = 4'd12;
  localparam logic [3:0] OP_FLAG2 = 4'd13;
  localparam logic [3:0] OP_OUT = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_gap;
    logic walk_last;
    logic sum_zero;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/token_rate_jitter_estimator_unit.sv
// top level of the token rate and jitter estimator
// depends on trje_pkg, trje_ctrl and trje_datapath
`timescale 1ns / 1ps
`default_nettype none
// Measures event rate, gap jitter and a clamped pacing scale over a sliding
// window of up to 16 timestamp gaps, one result beat per timestamp beat. A
// seeding or non-increasing timestamp goes from acceptance straight to the
// done state, skipping the arithmetic. A timestamp that adds a gap is worked
// through the ring walk with one 32x32 multiply per entry, 53 steps of the
// bit-pair square root, three 64-step passes of the one shared restoring
// divider and single setup and update steps between them. One item is worked
// on at a time; the next is taken as soon as the previous result sits in the
// output register, even while that result is stalled, and a stalled result
// holds the following one in its last cycle until the output register frees.
module token_rate_jitter_estimator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] timestamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [47:0]      rate_hz,
  output logic [23:0]      pace_scale,
  output logic [23:0]      gap_spread,
  output logic             rate_changed,
  output logic [31:0]      event_count,
  output logic [31:0]      change_count
);

  trje_pkg::cmd_t  cmd;
  trje_pkg::stat_t stat;

  trje_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  trje_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .timestamp    (timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .rate_hz      (rate_hz),
    .pace_scale   (pace_scale),
    .gap_spread   (gap_spread),
    .rate_changed (rate_changed),
    .event_count  (event_count),
    .change_count (change_count)
  );

endmodule
`default_nettype wire

>>> rtl/trje_ctrl.sv
// sequencer of the token rate and jitter estimator
// depends on trje_pkg; drives one datapath command per cycle
`timescale 1ns / 1ps
`default_nettype none
module trje_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire trje_pkg::stat_t stat,
  output trje_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WALK = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_SQ1 = 4'd3;
  localparam logic [3:0] S_SQ2 = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_CVLD = 4'd6;
  localparam logic [3:0] S_CVRUN = 4'd7;
  localparam logic [3:0] S_RTLD = 4'd8;
  localparam logic [3:0] S_RTRUN = 4'd9;
  localparam logic [3:0] S_SCLD = 4'd10;
  localparam logic [3:0] S_SCRUN = 4'd11;
  localparam logic [3:0] S_CLAMP = 4'd12;
  localparam logic [3:0] S_FLAG1 = 4'd13;
  localparam logic [3:0] S_FLAG2 = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = trje_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = trje_pkg::OP_ACCEPT;
          state_next = stat.is_gap ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        cmd.op = trje_pkg::OP_WALK;
        if (stat.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.op = trje_pkg::OP_DRAIN;
        state_next = stat.sum_zero ? S_FLAG1 : S_SQ1;
      end
      S_SQ1: begin
        cmd.op = trje_pkg::OP_SQ1;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.op = trje_pkg::OP_SQ2;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = trje_pkg::OP_SQRT;
        if (stat.sqrt_last) state_next = S_CVLD;
      end
      S_CVLD: begin
        cmd.op = trje_pkg::OP_CVLD;
        state_next = S_CVRUN;
      end
      S_CVRUN: begin
        cmd.op = trje_pkg::OP_DIV;
        if (stat.div_last) state_next = S_RTLD;
      end
      S_RTLD: begin
        cmd.op = trje_pkg::OP_RTLD;
        state_next = S_RTRUN;
      end
      S_RTRUN: begin
        cmd.op = trje_pkg::OP_DIV;
        if (stat.div_last) state_next = S_SCLD;
      end
      S_SCLD: begin
        cmd.op = trje_pkg::OP_SCLD;
        state_next = S_SCRUN;
      end
      S_SCRUN: begin
        cmd.op = trje_pkg::OP_DIV;
        if (stat.div_last) state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op = trje_pkg::OP_CLAMP;
        state_next = S_FLAG1;
      end
      S_FLAG1: begin
        cmd.op = trje_pkg::OP_FLAG1;
        state_next = S_FLAG2;
      end
      S_FLAG2: begin
        cmd.op = trje_pkg::OP_FLAG2;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = trje_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/trje_datapath.sv
// gap ring, accumulators, shared divider, square root unit and held results
// depends on trje_pkg; steered by commands from trje_ctrl
`timescale 1ns / 1ps
`default_nettype none
module trje_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire trje_pkg::cmd_t  cmd,
  output trje_pkg::stat_t      stat,
  input  wire logic            cfg_write,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [47:0]     cfg_data,
  input  wire logic [63:0]     timestamp,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           status,
  output logic [47:0]          rate_hz,
  output logic [23:0]          pace_scale,
  output logic [23:0]          gap_spread,
  output logic                 rate_changed,
  output logic [31:0]          event_count,
  output logic [31:0]          change_count
);

  localparam int SlotW = trje_pkg::SlotW;
  localparam int FillW = trje_pkg::FillW;

  // configuration
  logic [4:0]  window_length;
  logic [47:0] target_rate;
  logic [23:0] scale_floor, scale_ceiling;
  logic [15:0] change_threshold;

  // history
  logic [31:0]      ring [trje_pkg::Window];
  logic [SlotW-1:0] write_slot;
  logic [FillW-1:0] filled;
  logic [63:0]      last_time;
  logic             seeded;
  logic [47:0]      reference_rate, held_rate;
  logic [23:0]      held_scale, held_cv;
  logic [31:0]      events_seen, changes_seen;
  logic [1:0]       item_status;
  logic             fire;

  // work registers
  logic [SlotW-1:0] idx;
  logic [35:0]  sum;
  logic [67:0]  sumsq;
  logic [63:0]  prod;
  logic [72:0]  wq;
  logic [63:0]  p0;
  logic [35:0]  p1;
  logic [7:0]   p2;
  logic [105:0] rad;
  logic [54:0]  srem;
  logic [52:0]  root;
  logic [5:0]   cnt;
  logic [63:0]  dn;
  logic [47:0]  dd, drem;
  logic [23:0]  cv_new;
  logic [47:0]  rate_new;
  logic [63:0]  diffsh, thr;

  logic [FillW-1:0] used_w;
  logic [63:0]      gap_full;
  logic [31:0]      gap32;
  logic [SlotW:0]   ws_eff, ws_inc;
  logic [31:0]      cur;
  logic [71:0]      ss;
  logic [56:0]      srem_sh, trial;
  logic [48:0]      drem_sh;
  logic [63:0]      sc;
  logic [47:0]      diff;
  logic             out_free;

  always_comb begin
    if (window_length < 5'd2) used_w = FillW'(2);
    else if (window_length > 5'(trje_pkg::Window)) used_w = FillW'(trje_pkg::Window);
    else used_w = FillW'(window_length);
    gap_full = timestamp - last_time;
    gap32 = (gap_full[63:32] != 32'd0) ? 32'hFFFF_FFFF : gap_full[31:0];
    ws_eff = ({1'b0, write_slot} >= (SlotW+1)'(used_w)) ? '0 : {1'b0, write_slot};
    ws_inc = ws_eff + 1'b1;
    cur = ring[idx];
    ss = {8'd0, p0} + {3'd0, p1, 33'd0} + {p2, 64'd0};
    srem_sh = {srem, rad[105:104]};
    trial = {2'b00, root, 2'b01};
    drem_sh = {drem, dn[63]};
    sc = (rate_new == 48'd0) ? {40'd0, trje_pkg::ONE_Q16} : dn;
    if (sc < {40'd0, scale_floor}) sc = {40'd0, scale_floor};
    if (sc > {40'd0, scale_ceiling}) sc = {40'd0, scale_ceiling};
    diff = (held_rate > reference_rate) ? held_rate - reference_rate
                                        : reference_rate - held_rate;
    out_free = !out_valid || !out_stall;
  end

  always_comb begin
    stat.is_gap = seeded && (timestamp > last_time);
    stat.walk_last = ({1'b0, idx} == filled - 1'b1);
    stat.sum_zero = (sum == 36'd0);
    stat.sqrt_last = (cnt == trje_pkg::SQRT_LAST);
    stat.div_last = (cnt == trje_pkg::DIV_LAST);
    stat.out_free = out_free;
  end

  // ring entries past the fill count are never read, so they need no reset
  always_ff @(posedge clk) begin
    if (cmd.op == trje_pkg::OP_ACCEPT && seeded && timestamp > last_time) begin
      ring[ws_eff[SlotW-1:0]] <= gap32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= trje_pkg::WINDOW_RESET;
      target_rate <= trje_pkg::TARGET_RESET;
      scale_floor <= trje_pkg::SCALE_FLOOR_RESET;
      scale_ceiling <= trje_pkg::SCALE_CEILING_RESET;
      change_threshold <= trje_pkg::THRESHOLD_RESET;
      write_slot <= '0;
      filled <= '0;
      last_time <= '0;
      seeded <= 1'b0;
      reference_rate <= '0;
      held_rate <= '0;
      held_scale <= trje_pkg::ONE_Q16;
      held_cv <= '0;
      events_seen <= '0;
      changes_seen <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        trje_pkg::OP_ACCEPT: begin
          events_seen <= events_seen + 32'd1;
          fire <= 1'b0;
          idx <= '0;
          sum <= '0;
          sumsq <= '0;
          prod <= '0;
          last_time <= timestamp;
          if (!seeded) begin
            seeded <= 1'b1;
            item_status <= trje_pkg::STATUS_SEEDED;
          end else if (timestamp <= last_time) begin
            item_status <= trje_pkg::STATUS_IGNORED;
          end else begin
            item_status <= trje_pkg::STATUS_GAP;
            write_slot <= (ws_inc >= (SlotW+1)'(used_w)) ? '0 : ws_inc[SlotW-1:0];
            if (filled < used_w) filled <= filled + 1'b1;
          end
        end
        trje_pkg::OP_WALK: begin
          sum <= sum + {4'd0, cur};
          prod <= cur * cur;
          sumsq <= sumsq + {4'd0, prod};
          idx <= idx + 1'b1;
        end
        trje_pkg::OP_DRAIN: begin
          sumsq <= sumsq + {4'd0, prod};
        end
        trje_pkg::OP_SQ1: begin
          wq <= 73'(sumsq * filled);
          p0 <= sum[31:0] * sum[31:0];
          p1 <= sum[31:0] * sum[35:32];
          p2 <= sum[35:32] * sum[35:32];
        end
        trje_pkg::OP_SQ2: begin
          rad <= {1'b0, wq - {1'b0, ss}, 32'd0};
          srem <= '0;
          root <= '0;
          cnt <= '0;
        end
        trje_pkg::OP_SQRT: begin
          // two radicand bits per step, one root bit
          if (srem_sh >= trial) begin
            srem <= 55'(srem_sh - trial);
            root <= {root[51:0], 1'b1};
          end else begin
            srem <= srem_sh[54:0];
            root <= {root[51:0], 1'b0};
          end
          rad <= {rad[103:0], 2'b00};
          cnt <= cnt + 6'd1;
        end
        trje_pkg::OP_CVLD: begin
          dn <= {11'd0, root};
          dd <= {12'd0, sum};
          drem <= '0;
          cnt <= '0;
        end
        trje_pkg::OP_DIV: begin
          // restoring divide, quotient shifts into dn
          if (drem_sh >= {1'b0, dd}) begin
            drem <= 48'(drem_sh - {1'b0, dd});
            dn <= {dn[62:0], 1'b1};
          end else begin
            drem <= drem_sh[47:0];
            dn <= {dn[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
        end
        trje_pkg::OP_RTLD: begin
          cv_new <= (dn[63:24] != 40'd0) ? 24'hFF_FFFF : dn[23:0];
          dn <= 64'(filled * trje_pkg::RATE_K);
          dd <= {12'd0, sum};
          drem <= '0;
          cnt <= '0;
        end
        trje_pkg::OP_SCLD: begin
          rate_new <= (dn[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : dn[47:0];
          dn <= {target_rate, 16'd0};
          dd <= (dn[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : dn[47:0];
          drem <= '0;
          cnt <= '0;
        end
        trje_pkg::OP_CLAMP: begin
          held_rate <= rate_new;
          held_scale <= sc[23:0];
          held_cv <= cv_new;
        end
        trje_pkg::OP_FLAG1: begin
          diffsh <= {diff, 16'd0};
          thr <= change_threshold * reference_rate;
        end
        trje_pkg::OP_FLAG2: begin
          if (reference_rate != 48'd0) begin
            if (diffsh > thr) begin
              fire <= 1'b1;
              changes_seen <= changes_seen + 32'd1;
              reference_rate <= held_rate;
            end
          end else if (held_rate != 48'd0) begin
            reference_rate <= held_rate;
          end
        end
        trje_pkg::OP_OUT: begin
          out_valid <= 1'b1;
          status <= item_status;
          rate_hz <= held_rate;
          pace_scale <= held_scale;
          gap_spread <= held_cv;
          rate_changed <= fire;
          event_count <= events_seen;
          change_count <= changes_seen;
        end
        default: ;
      endcase
      if (cmd.op != trje_pkg::OP_OUT && out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          trje_pkg::REG_WINDOW_LENGTH: begin
            window_length <= cfg_data[4:0];
            write_slot <= '0;
            filled <= '0;
            last_time <= '0;
            seeded <= 1'b0;
            reference_rate <= '0;
          end
          trje_pkg::REG_TARGET_RATE: target_rate <= cfg_data;
          trje_pkg::REG_SCALE_FLOOR: scale_floor <= cfg_data[23:0];
          trje_pkg::REG_SCALE_CEILING: scale_ceiling <= cfg_data[23:0];
          trje_pkg::REG_CHANGE_THRESHOLD: change_threshold <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_token_rate_jitter_estimator_unit.sv
// self-checking testbench for token_rate_jitter_estimator_unit
// depends on trje_pkg and the top level; a scoreboard class predicts every result beat
`timescale 1ns / 1ps
`default_nettype none
module tb_token_rate_jitter_estimator_unit;

  localparam int CycleLimit = 3000000;

  typedef struct {
    logic [1:0]  status;
    logic [47:0] rate_hz;
    logic [23:0] pace_scale;
    logic [23:0] gap_spread;
    logic        rate_changed;
    logic [31:0] event_count;
    logic [31:0] change_count;
  } meter_beat_t;

  class rate_scoreboard;
    logic [31:0] gaps[trje_pkg::Window];
    int unsigned slot, fill;
    logic [63:0] last_ts;
    bit          seeded;
    logic [47:0] ref_rate, rate_now;
    logic [23:0] scale_now, cv_now;
    logic [31:0] events, changes;
    logic [4:0]  win_len;
    logic [47:0] target;
    logic [23:0] scale_lo, scale_hi;
    logic [15:0] thresh;
    meter_beat_t pending[$];
    int          errors;

    function void clear_history();
      foreach (gaps[i]) gaps[i] = '0;
      slot = 0;
      fill = 0;
      last_ts = '0;
      seeded = 0;
      ref_rate = '0;
    endfunction

    function void reset_all();
      clear_history();
      rate_now = '0;
      scale_now = trje_pkg::ONE_Q16;
      cv_now = '0;
      events = '0;
      changes = '0;
      win_len = trje_pkg::WINDOW_RESET;
      target = trje_pkg::TARGET_RESET;
      scale_lo = trje_pkg::SCALE_FLOOR_RESET;
      scale_hi = trje_pkg::SCALE_CEILING_RESET;
      thresh = trje_pkg::THRESHOLD_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        trje_pkg::REG_WINDOW_LENGTH: begin
          win_len = val[4:0];
          clear_history();
        end
        trje_pkg::REG_TARGET_RATE: target = val;
        trje_pkg::REG_SCALE_FLOOR: scale_lo = val[23:0];
        trje_pkg::REG_SCALE_CEILING: scale_hi = val[23:0];
        trje_pkg::REG_CHANGE_THRESHOLD: thresh = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] root_of(logic [127:0] x);
      logic [63:0] r, c;
      logic [127:0] c2;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        c2 = {64'd0, c} * {64'd0, c};
        if (c2 <= x) r = c;
      end
      return r;
    endfunction

    function void refresh_stats();
      logic [63:0] sum, rate, scale, cv;
      logic [127:0] sq, n;
      sum = '0;
      sq = '0;
      for (int i = 0; i < fill; i++) begin
        sum += gaps[i];
        sq += {96'd0, gaps[i]} * {96'd0, gaps[i]};
      end
      if (sum == 0) return;
      n = (sq * fill - {64'd0, sum} * {64'd0, sum}) << 32;
      cv = root_of(n) / sum;
      if (cv > 64'hFFFFFF) cv = 64'hFFFFFF;
      rate = (64'(fill) * 64'd1000000000 * 64'd65536) / sum;
      if (rate > 64'hFFFF_FFFF_FFFF) rate = 64'hFFFF_FFFF_FFFF;
      if (rate > 0) scale = {target, 16'd0} / rate;
      else scale = 64'd65536;
      if (scale < scale_lo) scale = scale_lo;
      if (scale > scale_hi) scale = scale_hi;
      rate_now = rate[47:0];
      scale_now = scale[23:0];
      cv_now = cv[23:0];
    endfunction

    function void note_beat(logic [63:0] ts);
      meter_beat_t e;
      logic [63:0] gap, diff;
      int unsigned w;
      e.rate_changed = 0;
      events++;
      if (!seeded) begin
        last_ts = ts;
        seeded = 1;
        e.status = trje_pkg::STATUS_SEEDED;
      end else if (ts <= last_ts) begin
        last_ts = ts;
        e.status = trje_pkg::STATUS_IGNORED;
      end else begin
        gap = ts - last_ts;
        last_ts = ts;
        w = win_len < 2 ? 2 : (win_len > trje_pkg::Window ? trje_pkg::Window : win_len);
        if (gap > 64'hFFFF_FFFF) gap = 64'hFFFF_FFFF;
        if (slot >= w) slot = 0;
        gaps[slot] = gap[31:0];
        slot = (slot + 1 >= w) ? 0 : slot + 1;
        if (fill < w) fill++;
        refresh_stats();
        if (ref_rate > 0) begin
          diff = rate_now > ref_rate ? rate_now - ref_rate : ref_rate - rate_now;
          if ((diff << 16) > 64'(thresh) * 64'(ref_rate)) begin
            e.rate_changed = 1;
            changes++;
            ref_rate = rate_now;
          end
        end else if (rate_now > 0) begin
          ref_rate = rate_now;
        end
        e.status = trje_pkg::STATUS_GAP;
      end
      e.rate_hz = rate_now;
      e.pace_scale = scale_now;
      e.gap_spread = cv_now;
      e.event_count = events;
      e.change_count = changes;
      pending.push_back(e);
    endfunction

    function void compare(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp, act);
      end
    endfunction

    function void check_beat(meter_beat_t got);
      meter_beat_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with no expectation, status %0d", $realtime, got.status);
        return;
      end
      e = pending.pop_front();
      compare("status", 64'(e.status), 64'(got.status));
      compare("rate_hz", 64'(e.rate_hz), 64'(got.rate_hz));
      compare("pace_scale", 64'(e.pace_scale), 64'(got.pace_scale));
      compare("gap_spread", 64'(e.gap_spread), 64'(got.gap_spread));
      compare("rate_changed", 64'(e.rate_changed), 64'(got.rate_changed));
      compare("event_count", 64'(e.event_count), 64'(got.event_count));
      compare("change_count", 64'(e.change_count), 64'(got.change_count));
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid, in_stall;
  logic [63:0] timestamp;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [47:0] rate_hz;
  logic [23:0] pace_scale, gap_spread;
  logic        rate_changed;
  logic [31:0] event_count, change_count;

  token_rate_jitter_estimator_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .timestamp(timestamp),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .rate_hz(rate_hz), .pace_scale(pace_scale),
    .gap_spread(gap_spread), .rate_changed(rate_changed),
    .event_count(event_count), .change_count(change_count)
  );

  rate_scoreboard meter = new();
  bit          calm;
  int unsigned idle_odds;
  logic [63:0] now_ns;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_token_rate_jitter_estimator_unit: FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(1, 18);
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    meter_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status;
      got.rate_hz = rate_hz;
      got.pace_scale = pace_scale;
      got.gap_spread = gap_spread;
      got.rate_changed = rate_changed;
      got.event_count = event_count;
      got.change_count = change_count;
      meter.check_beat(got);
    end
  end

  task automatic send_ts(logic [63:0] ts);
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1;
    timestamp <= ts;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    meter.note_beat(ts);
    now_ns = ts;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (meter.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    meter.write_reg(idx, val);
  endtask

  task automatic set_regs(logic [47:0] wl, logic [47:0] tr, logic [23:0] lo,
                          logic [23:0] hi, logic [15:0] th);
    write_reg(trje_pkg::REG_WINDOW_LENGTH, wl);
    write_reg(trje_pkg::REG_TARGET_RATE, tr);
    write_reg(trje_pkg::REG_SCALE_FLOOR,
              48'({$urandom, $urandom}) & 48'hFFFF_FF00_0000 | {24'd0, lo});
    write_reg(trje_pkg::REG_SCALE_CEILING, {24'd0, hi});
    write_reg(trje_pkg::REG_CHANGE_THRESHOLD, {32'd0, th});
  endtask

  // mostly rising timestamps around a drifting tempo, plus backsteps and noise
  task automatic random_run(int count);
    logic [63:0] tempo, gap;
    tempo = 64'($urandom_range(1000, 5000000));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 30) == 0) tempo = 64'($urandom_range(1, 50000000));
      if (k % 100 == 50) idle_odds = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(0, 19))
        0: send_ts(now_ns - 64'($urandom_range(0, 1000)));
        1: send_ts({$urandom, $urandom});
        2: send_ts(now_ns + {$urandom_range(0, 3), $urandom});
        3: send_ts(now_ns + 64'($urandom_range(1, 20)));
        default: begin
          gap = tempo + 64'($urandom_range(0, 32'(tempo / 4 + 1)));
          send_ts(now_ns + gap);
        end
      endcase
    end
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    timestamp = '0;
    calm = 0;
    idle_odds = 3;
    now_ns = '0;
    meter.reset_all();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // seeding, equal, extremes, saturated gaps, a steady run then a jump
    send_ts(64'd0);
    send_ts(64'd0);
    send_ts(64'd1);
    send_ts(64'hFFFF_FFFF_FFFF_FFFF);
    send_ts(64'd0);
    send_ts(64'd5);
    send_ts(64'd5 + 64'h1_0000_0000);
    send_ts(now_ns + 64'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) send_ts(now_ns + 64'd1000000);
    for (int k = 0; k < 5; k++) send_ts(now_ns + 64'd100000 + 64'(k * 7919));
    send_ts(now_ns + 64'd3);
    drain();
    random_run(200);

    // shortest window, zero target, widest clamps, any change flags
    drain();
    set_regs(48'd2, 48'd0, 24'd0, 24'hFFFFFF, 16'd0);
    random_run(220);

    // window below range, top target, crossed clamps, top threshold
    drain();
    set_regs(48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFE0, 48'hFFFF_FFFF_FFFF,
             24'hFFFFFF, 24'd0, 16'hFFFF);
    random_run(200);

    // window above range, unknown indexes
    drain();
    set_regs(48'd31, 48'({$urandom, $urandom}), 24'd1000, 24'd2000000, 16'd3000);
    write_reg(3'd5, 48'({$urandom, $urandom}));
    write_reg(3'd7, 48'({$urandom, $urandom}));
    random_run(220);

    drain();
    set_regs(48'd1, 48'd65536000, 24'd6554, 24'd655360, 16'd600);
    random_run(200);

    drain();
    set_regs(48'd7, 48'({$urandom, $urandom}), 24'($urandom), 24'($urandom),
             16'($urandom));
    random_run(120);

    drain();
    set_regs(48'd16, trje_pkg::TARGET_RESET, trje_pkg::SCALE_FLOOR_RESET,
             trje_pkg::SCALE_CEILING_RESET, trje_pkg::THRESHOLD_RESET);
    random_run(80);
    calm = 1;
    random_run(150);

    in_valid <= 0;
    while (meter.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (meter.errors == 0 && meter.pending.size() == 0)
      $display("tb_token_rate_jitter_estimator_unit: PASS");
    else
      $display("tb_token_rate_jitter_estimator_unit: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> token_rate_jitter_estimator_unit.f
rtl/trje_pkg.sv
rtl/trje_ctrl.sv
rtl/trje_datapath.sv
rtl/token_rate_jitter_estimator_unit.sv
tb/tb_token_rate_jitter_estimator_unit.sv
